// ===== rtl/core/aft_pkg.sv =====
// ----------------------------------------------------------------------------
// aft_pkg: shared types and constants for the affine point transform
// Q16.16 word type, command codes, register indexes, reset values and the
// structs that carry items from one pipeline stage to the next.
// ----------------------------------------------------------------------------
package aft_pkg;

    // Q16.16 two's complement word, sign handled explicitly at each use
    typedef logic [31:0] q_t;

    // Command codes
    localparam logic [1:0] CMD_POINT     = 2'd0;
    localparam logic [1:0] CMD_VECTOR    = 2'd1;
    localparam logic [1:0] CMD_INV_POINT = 2'd2;
    localparam logic [1:0] CMD_INV_VEC   = 2'd3;

    // Configuration register indexes
    localparam int           NUM_REGS    = 6;
    localparam int           IDX_W       = 3;
    localparam logic [IDX_W-1:0] REG_ROW1_C12 = 3'd0;
    localparam logic [IDX_W-1:0] REG_ROW1_C3T = 3'd1;
    localparam logic [IDX_W-1:0] REG_ROW2_C12 = 3'd2;
    localparam logic [IDX_W-1:0] REG_ROW2_C3T = 3'd3;
    localparam logic [IDX_W-1:0] REG_ROW3_C12 = 3'd4;
    localparam logic [IDX_W-1:0] REG_ROW3_C3T = 3'd5;

    // Reset values: identity matrix, zero translation
    localparam logic [63:0] RST_ROW1_C12 = 64'h0000_0000_0001_0000;
    localparam logic [63:0] RST_ROW1_C3T = 64'h0000_0000_0000_0000;
    localparam logic [63:0] RST_ROW2_C12 = 64'h0001_0000_0000_0000;
    localparam logic [63:0] RST_ROW2_C3T = 64'h0000_0000_0000_0000;
    localparam logic [63:0] RST_ROW3_C12 = 64'h0000_0000_0000_0000;
    localparam logic [63:0] RST_ROW3_C3T = 64'h0000_0000_0001_0000;

    // Saturation limits
    localparam q_t Q_MAX = 32'h7FFF_FFFF;
    localparam q_t Q_MIN = 32'h8000_0000;

    // Width of a product after the floor shift by 16
    localparam int PSH_W = 48;
    // Width of a pair sum
    localparam int PAIR_W = PSH_W + 1;
    // Width of the full component sum
    localparam int SUM_W = PAIR_W + 1;

    // Matrix (row, column) and translation
    typedef struct packed {
        q_t [2:0][2:0] m;
        q_t [2:0]      t;
    } aft_coef_t;

    // After the input stage
    typedef struct packed {
        logic [1:0] cmd;
        q_t [2:0]   v;
        logic       ovf;
    } aft_vec_t;

    // After the multiplier stage
    typedef struct packed {
        logic                 add_t;
        logic [2:0][2:0][63:0] p;
        logic                 ovf;
    } aft_prod_t;

    // After the pair-add stage
    typedef struct packed {
        logic [2:0][PAIR_W-1:0] a;
        logic [2:0][PAIR_W-1:0] b;
        logic                   ovf;
    } aft_pair_t;

    // Result item
    typedef struct packed {
        q_t [2:0] r;
        logic     ovf;
    } aft_res_t;

endpackage

// ===== rtl/core/aft_sub.sv =====
// ----------------------------------------------------------------------------
// aft_sub: input stage
// Registers the incoming transaction; in inverse point mode it subtracts the
// translation first and saturates each difference to 32 bits.
// ----------------------------------------------------------------------------
module aft_sub (
    input  logic               aclk,
    input  logic               aresetn,
    input  aft_pkg::aft_coef_t coef,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         in_cmd,
    input  aft_pkg::q_t [2:0]  in_v,
    output logic               out_valid,
    input  logic               out_ready,
    output aft_pkg::aft_vec_t  out_data
);

    logic              valid_reg;
    aft_pkg::aft_vec_t data_reg;
    aft_pkg::aft_vec_t data_next;

    // Optional v - t with saturation
    always_comb begin
        logic [32:0] diff;
        data_next.cmd = in_cmd;
        data_next.ovf = 1'b0;
        for (int i = 0; i < 3; i++) begin
            diff = {in_v[i][31], in_v[i]} - {coef.t[i][31], coef.t[i]};
            if (in_cmd == aft_pkg::CMD_INV_POINT) begin
                if (diff[32] != diff[31]) begin
                    data_next.v[i] = diff[32] ? aft_pkg::Q_MIN : aft_pkg::Q_MAX;
                    data_next.ovf  = 1'b1;
                end else begin
                    data_next.v[i] = diff[31:0];
                end
            end else begin
                data_next.v[i] = in_v[i];
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/core/aft_mul.sv =====
// ----------------------------------------------------------------------------
// aft_mul: multiplier stage
// Picks the matrix or its transpose by command and forms the nine exact
// 32x32 signed products in parallel.
// ----------------------------------------------------------------------------
module aft_mul (
    input  logic               aclk,
    input  logic               aresetn,
    input  aft_pkg::aft_coef_t coef,
    input  logic               in_valid,
    output logic               in_ready,
    input  aft_pkg::aft_vec_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output aft_pkg::aft_prod_t out_data
);

    logic               valid_reg;
    aft_pkg::aft_prod_t data_reg;
    aft_pkg::aft_prod_t data_next;

    // Row i, column j: m[i][j] forward, m[j][i] in the inverse modes
    always_comb begin
        aft_pkg::q_t        c;
        logic signed [63:0] prod;
        data_next.add_t = (in_data.cmd == aft_pkg::CMD_POINT);
        data_next.ovf   = in_data.ovf;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                c    = in_data.cmd[1] ? coef.m[j][i] : coef.m[i][j];
                prod = $signed(c) * $signed(in_data.v[j]);
                data_next.p[i][j] = prod;
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/core/aft_sum.sv =====
// ----------------------------------------------------------------------------
// aft_sum: accumulate and saturate
// Two stages: floor-shifted products are added in pairs (translation joins
// the third product in point mode), then the pairs are summed and clamped
// to signed 32 bits into the output register.
// ----------------------------------------------------------------------------
module aft_sum (
    input  logic               aclk,
    input  logic               aresetn,
    input  aft_pkg::aft_coef_t coef,
    input  logic               in_valid,
    output logic               in_ready,
    input  aft_pkg::aft_prod_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output aft_pkg::aft_res_t  out_data
);

    localparam int PSH_W  = aft_pkg::PSH_W;
    localparam int PAIR_W = aft_pkg::PAIR_W;
    localparam int SUM_W  = aft_pkg::SUM_W;

    logic               pair_valid_reg;
    logic               pair_ready;
    aft_pkg::aft_pair_t pair_reg;
    aft_pkg::aft_pair_t pair_next;
    logic               res_valid_reg;
    aft_pkg::aft_res_t  res_reg;
    aft_pkg::aft_res_t  res_next;

    // Pair adds; bits 63:16 of a product are its floor shift by 16
    always_comb begin
        logic [PSH_W-1:0] s0, s1, s2;
        logic [PAIR_W-1:0] tx;
        pair_next.ovf = in_data.ovf;
        for (int i = 0; i < 3; i++) begin
            s0 = in_data.p[i][0][63:16];
            s1 = in_data.p[i][1][63:16];
            s2 = in_data.p[i][2][63:16];
            tx = in_data.add_t ? {{(PAIR_W-32){coef.t[i][31]}}, coef.t[i]} : '0;
            pair_next.a[i] = {s0[PSH_W-1], s0} + {s1[PSH_W-1], s1};
            pair_next.b[i] = {s2[PSH_W-1], s2} + tx;
        end
    end

    // Final add and clamp
    always_comb begin
        logic [SUM_W-1:0] s;
        res_next.ovf = pair_reg.ovf;
        for (int i = 0; i < 3; i++) begin
            s = {pair_reg.a[i][PAIR_W-1], pair_reg.a[i]} +
                {pair_reg.b[i][PAIR_W-1], pair_reg.b[i]};
            if (s[SUM_W-1:31] == '0 || s[SUM_W-1:31] == '1) begin
                res_next.r[i] = s[31:0];
            end else begin
                res_next.r[i] = s[SUM_W-1] ? aft_pkg::Q_MIN : aft_pkg::Q_MAX;
                res_next.ovf  = 1'b1;
            end
        end
    end

    // Handshake chain
    assign pair_ready = !res_valid_reg || out_ready;
    assign in_ready   = !pair_valid_reg || pair_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end else begin
            if (in_ready) begin
                pair_valid_reg <= in_valid;
            end
            if (pair_ready) begin
                res_valid_reg <= pair_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            pair_reg <= pair_next;
        end
        if (pair_valid_reg && pair_ready) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

endmodule

// ===== rtl/core/affine_point_transform.sv =====
// ----------------------------------------------------------------------------
// affine_point_transform: 3x3 matrix plus translation on Q16.16 vectors
// Four-stage pipeline: input/subtract, multiply, pair add, sum and clamp.
// ----------------------------------------------------------------------------
// Accepts one vector per clock while the output is not stalled and returns one
// result per vector, in order. Throughput is one transaction per cycle, set by
// the nine parallel 32x32 multipliers in the second stage; backpressure on the
// master side stalls only as far back as needed, so empty stages still fill.
// Commands: point M*v+t, vector M*v, inverse point M^T*(v-t), inverse vector
// M^T*v. Products are floored by 16 bits, sums (and inverse-point differences)
// clamp to signed 32 bits and set the overflow flag. Registers come up as
// identity with zero translation and should be written only while no
// transaction is in flight.
module affine_point_transform (
    input  logic                      aclk,
    input  logic                      aresetn,
    // Configuration write port
    input  logic                      cfg_we,
    input  logic [aft_pkg::IDX_W-1:0] cfg_index,
    input  logic [63:0]               cfg_wdata,
    // Input channel
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [95:0]               s_tdata,   // x_in, y_in, z_in
    input  logic [1:0]                s_tuser,   // command
    // Result channel
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [95:0]               m_tdata,   // x_out, y_out, z_out
    output logic                      m_tuser    // overflow
);

    logic [63:0] row1_c12_reg, row1_c3t_reg;
    logic [63:0] row2_c12_reg, row2_c3t_reg;
    logic [63:0] row3_c12_reg, row3_c3t_reg;

    aft_pkg::aft_coef_t coef;
    aft_pkg::q_t [2:0]  in_v;

    logic               vec_valid, vec_ready;
    aft_pkg::aft_vec_t  vec_data;
    logic               prod_valid, prod_ready;
    aft_pkg::aft_prod_t prod_data;
    aft_pkg::aft_res_t  res_data;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row1_c12_reg <= aft_pkg::RST_ROW1_C12;
            row1_c3t_reg <= aft_pkg::RST_ROW1_C3T;
            row2_c12_reg <= aft_pkg::RST_ROW2_C12;
            row2_c3t_reg <= aft_pkg::RST_ROW2_C3T;
            row3_c12_reg <= aft_pkg::RST_ROW3_C12;
            row3_c3t_reg <= aft_pkg::RST_ROW3_C3T;
        end else if (cfg_we) begin
            case (cfg_index)
                aft_pkg::REG_ROW1_C12: row1_c12_reg <= cfg_wdata;
                aft_pkg::REG_ROW1_C3T: row1_c3t_reg <= cfg_wdata;
                aft_pkg::REG_ROW2_C12: row2_c12_reg <= cfg_wdata;
                aft_pkg::REG_ROW2_C3T: row2_c3t_reg <= cfg_wdata;
                aft_pkg::REG_ROW3_C12: row3_c12_reg <= cfg_wdata;
                aft_pkg::REG_ROW3_C3T: row3_c3t_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Unpack matrix and translation
    always_comb begin
        coef.m[0][0] = row1_c12_reg[31:0];
        coef.m[0][1] = row1_c12_reg[63:32];
        coef.m[0][2] = row1_c3t_reg[31:0];
        coef.t[0]    = row1_c3t_reg[63:32];
        coef.m[1][0] = row2_c12_reg[31:0];
        coef.m[1][1] = row2_c12_reg[63:32];
        coef.m[1][2] = row2_c3t_reg[31:0];
        coef.t[1]    = row2_c3t_reg[63:32];
        coef.m[2][0] = row3_c12_reg[31:0];
        coef.m[2][1] = row3_c12_reg[63:32];
        coef.m[2][2] = row3_c3t_reg[31:0];
        coef.t[2]    = row3_c3t_reg[63:32];
    end

    assign in_v[0] = s_tdata[31:0];
    assign in_v[1] = s_tdata[63:32];
    assign in_v[2] = s_tdata[95:64];

    aft_sub u_sub (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .coef      (coef),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tuser),
        .in_v      (in_v),
        .out_valid (vec_valid),
        .out_ready (vec_ready),
        .out_data  (vec_data)
    );

    aft_mul u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .coef      (coef),
        .in_valid  (vec_valid),
        .in_ready  (vec_ready),
        .in_data   (vec_data),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_data  (prod_data)
    );

    aft_sum u_sum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .coef      (coef),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_data   (prod_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res_data)
    );

    assign m_tdata = {res_data.r[2], res_data.r[1], res_data.r[0]};
    assign m_tuser = res_data.ovf;

endmodule

// ===== dv/affine_point_transform_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_point_transform_test: self-checking bench for the affine transform
// Drives Q16.16 vectors with all four commands through several matrix and
// translation settings and predicts each transformed vector and its overflow
// flag. Matrix settings cover identity, corner values, rotations and random
// words. Both stream sides idle at random, and one long output stall backs
// the pipeline up into the input.
// ----------------------------------------------------------------------------
module affine_point_transform_test;

    localparam int          PIPE_LATENCY = 4;
    localparam int          IDLE_LIMIT   = 2000;
    localparam int          LONG_HOLD    = 300;
    localparam int          BURST_ITEMS  = 40;
    localparam int          PHASE_ITEMS  = 150;
    localparam longint      WORD_HI      = 64'sd2147483647;
    localparam longint      WORD_LO      = -64'sd2147483648;
    localparam logic [31:0] Q_ONE        = 32'h0001_0000;
    localparam logic [31:0] Q_NEG_ONE    = 32'hFFFF_0000;
    // Indexes past the register file; writes to them must be dropped
    localparam logic [aft_pkg::IDX_W-1:0] REG_BEYOND_LO = 3'd6;
    localparam logic [aft_pkg::IDX_W-1:0] REG_BEYOND_HI = 3'd7;

    typedef enum {COEF_FULL, COEF_UNIT, COEF_EXTREME} coef_mix_t;

    // Expected result of one transaction; r[0] is x
    typedef struct packed {
        logic [2:0][31:0] r;
        logic             ovf;
    } xf_result_t;

    logic                        aclk;
    logic                        aresetn;
    logic                        cfg_we;
    logic [aft_pkg::IDX_W-1:0]   cfg_index;
    logic [63:0]                 cfg_wdata;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [95:0]                 s_tdata;   // x_in, y_in, z_in
    logic [1:0]                  s_tuser;   // command
    logic                        m_tvalid;
    logic                        m_tready;
    logic [95:0]                 m_tdata;   // x_out, y_out, z_out
    logic                        m_tuser;   // overflow

    // Shadow of the coefficient registers
    logic [63:0]          coef_regs [aft_pkg::NUM_REGS];
    xf_result_t           pending_results [$];
    int                   mismatch_count = 0;
    int                   idle_cycles    = 0;
    int                   hold_cycles    = 0;
    int                   burst_left     = 0;
    bit                   gaps_on        = 1'b0;
    bit                   sink_stall_en  = 1'b0;

    affine_point_transform dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic longint sx(input logic [31:0] w);
        return longint'(signed'(w));
    endfunction

    // Exact product, floored by the 16 fraction bits
    function automatic longint qprod(input longint a, input longint b);
        return (a * b) >>> 16;
    endfunction

    function automatic longint clamp32(input longint val, inout logic hit);
        if (val > WORD_HI) begin
            hit = 1'b1;
            return WORD_HI;
        end
        if (val < WORD_LO) begin
            hit = 1'b1;
            return WORD_LO;
        end
        return val;
    endfunction

    function automatic xf_result_t predict_transform(input logic [1:0] cmd,
                                                     input logic [2:0][31:0] vin);
        longint     m [3][3];
        longint     t [3];
        longint     v [3];
        longint     s;
        xf_result_t res;
        int         i;
        m[0][0] = sx(coef_regs[aft_pkg::REG_ROW1_C12][31:0]);
        m[0][1] = sx(coef_regs[aft_pkg::REG_ROW1_C12][63:32]);
        m[0][2] = sx(coef_regs[aft_pkg::REG_ROW1_C3T][31:0]);
        t[0]    = sx(coef_regs[aft_pkg::REG_ROW1_C3T][63:32]);
        m[1][0] = sx(coef_regs[aft_pkg::REG_ROW2_C12][31:0]);
        m[1][1] = sx(coef_regs[aft_pkg::REG_ROW2_C12][63:32]);
        m[1][2] = sx(coef_regs[aft_pkg::REG_ROW2_C3T][31:0]);
        t[1]    = sx(coef_regs[aft_pkg::REG_ROW2_C3T][63:32]);
        m[2][0] = sx(coef_regs[aft_pkg::REG_ROW3_C12][31:0]);
        m[2][1] = sx(coef_regs[aft_pkg::REG_ROW3_C12][63:32]);
        m[2][2] = sx(coef_regs[aft_pkg::REG_ROW3_C3T][31:0]);
        t[2]    = sx(coef_regs[aft_pkg::REG_ROW3_C3T][63:32]);
        res.ovf = 1'b0;
        // Inverse point clamps v - t before the transposed product
        for (i = 0; i < 3; i++) begin
            v[i] = sx(vin[i]);
            if (cmd == aft_pkg::CMD_INV_POINT)
                v[i] = clamp32(v[i] - t[i], res.ovf);
        end
        for (i = 0; i < 3; i++) begin
            if (cmd == aft_pkg::CMD_POINT || cmd == aft_pkg::CMD_VECTOR)
                s = qprod(m[i][0], v[0]) + qprod(m[i][1], v[1]) + qprod(m[i][2], v[2]);
            else
                s = qprod(m[0][i], v[0]) + qprod(m[1][i], v[1]) + qprod(m[2][i], v[2]);
            if (cmd == aft_pkg::CMD_POINT)
                s += t[i];
            res.r[i] = 32'(clamp32(s, res.ovf));
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Random values
    // ------------------------------------------------------------------
    function automatic logic [31:0] extreme_word();
        case ($urandom_range(0, 5))
            0:       return aft_pkg::Q_MAX;
            1:       return aft_pkg::Q_MIN;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4:       return Q_ONE;
            default: return Q_NEG_ONE;
        endcase
    endfunction

    function automatic logic [31:0] rand_coord();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return $urandom;
        if (pick < 8)
            return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
        if (pick == 8)
            return extreme_word();
        return 32'($urandom_range(0, 3)) - 32'd1;
    endfunction

    function automatic logic [31:0] rand_coef(input coef_mix_t mix);
        case (mix)
            COEF_UNIT:    return 32'($urandom_range(0, 2 * Q_ONE)) - Q_ONE;
            COEF_EXTREME: return extreme_word();
            default:      return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [aft_pkg::IDX_W-1:0] idx, input logic [63:0] val,
                             input bit last);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        if (idx < aft_pkg::NUM_REGS)
            coef_regs[idx] = val;
        if (last)
            cfg_we <= 1'b0;
    endtask

    task automatic program_matrix(input logic [63:0] r1c12, input logic [63:0] r1c3t,
                                  input logic [63:0] r2c12, input logic [63:0] r2c3t,
                                  input logic [63:0] r3c12, input logic [63:0] r3c3t);
        write_reg(aft_pkg::REG_ROW1_C12, r1c12, 1'b0);
        write_reg(aft_pkg::REG_ROW1_C3T, r1c3t, 1'b0);
        write_reg(aft_pkg::REG_ROW2_C12, r2c12, 1'b0);
        write_reg(aft_pkg::REG_ROW2_C3T, r2c3t, 1'b0);
        write_reg(aft_pkg::REG_ROW3_C12, r3c12, 1'b0);
        write_reg(aft_pkg::REG_ROW3_C3T, r3c3t, 1'b1);
    endtask

    // Offer one vector, with a random gap at the start of each burst
    task automatic send_item(input logic [1:0] cmd, input logic [31:0] x,
                             input logic [31:0] y, input logic [31:0] z);
        int gap;
        if (gaps_on && burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 3);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {z, y, x};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(predict_transform(cmd, {z, y, x}));
    endtask

    task automatic send_random(input int count);
        int n;
        for (n = 0; n < count; n++)
            send_item(2'($urandom_range(0, 3)), rand_coord(), rand_coord(), rand_coord());
    endtask

    // Stop offering and wait for the pipeline to empty
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (PIPE_LATENCY) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Identity matrix and zero translation straight out of reset
    task automatic test_reset_identity();
        send_item(aft_pkg::CMD_POINT,     32'h0, 32'h0, 32'h0);
        send_item(aft_pkg::CMD_POINT,     aft_pkg::Q_MAX, aft_pkg::Q_MIN, 32'hFFFF_FFFF);
        send_item(aft_pkg::CMD_VECTOR,    32'h1, aft_pkg::Q_MAX, Q_NEG_ONE);
        send_item(aft_pkg::CMD_INV_POINT, aft_pkg::Q_MIN, aft_pkg::Q_MAX, Q_ONE);
        send_item(aft_pkg::CMD_INV_VEC,   32'hFFFF_FFFF, 32'h1234_5678, aft_pkg::Q_MIN);
        drain_results();
    endtask

    // Full-scale coefficients: sums clamp both ways, differences clamp,
    // negative products floor toward minus infinity
    task automatic test_saturation_corners();
        program_matrix({aft_pkg::Q_MAX, aft_pkg::Q_MAX}, {aft_pkg::Q_MAX, aft_pkg::Q_MAX},
                       {aft_pkg::Q_MIN, aft_pkg::Q_MIN}, {aft_pkg::Q_MIN, aft_pkg::Q_MIN},
                       {Q_NEG_ONE, Q_ONE}, {32'h0001_8000, 32'h0000_0001});
        send_item(aft_pkg::CMD_POINT,     aft_pkg::Q_MAX, aft_pkg::Q_MAX, aft_pkg::Q_MAX);
        send_item(aft_pkg::CMD_VECTOR,    aft_pkg::Q_MIN, aft_pkg::Q_MIN, aft_pkg::Q_MIN);
        send_item(aft_pkg::CMD_INV_POINT, aft_pkg::Q_MIN, aft_pkg::Q_MAX, aft_pkg::Q_MIN);
        send_item(aft_pkg::CMD_INV_VEC,   aft_pkg::Q_MAX, 32'hFFFF_FFFF, 32'h1);
        send_item(aft_pkg::CMD_POINT,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(aft_pkg::CMD_VECTOR,    Q_ONE, 32'h0, Q_NEG_ONE);
        drain_results();
    endtask

    // Quarter turn about z with an offset, so inverse modes undo the forward ones
    task automatic test_quarter_turn();
        program_matrix({Q_NEG_ONE, 32'h0}, {32'h0002_0000, 32'h0},
                       {32'h0, Q_ONE}, {32'hFFFD_0000, 32'h0},
                       {32'h0, 32'h0}, {32'h0000_8000, Q_ONE});
        send_item(aft_pkg::CMD_POINT,     Q_ONE, 32'h0002_0000, 32'h0003_0000);
        send_item(aft_pkg::CMD_VECTOR,    Q_ONE, 32'h0002_0000, 32'h0003_0000);
        send_item(aft_pkg::CMD_INV_POINT, Q_ONE, 32'h0002_0000, 32'h0003_0000);
        send_item(aft_pkg::CMD_INV_VEC,   Q_ONE, 32'h0002_0000, 32'h0003_0000);
        send_item(aft_pkg::CMD_POINT,     aft_pkg::Q_MIN, aft_pkg::Q_MAX, 32'h0);
        send_item(aft_pkg::CMD_VECTOR,    aft_pkg::Q_MIN, aft_pkg::Q_MAX, 32'h0);
        send_item(aft_pkg::CMD_INV_POINT, aft_pkg::Q_MIN, aft_pkg::Q_MAX, 32'h0);
        send_item(aft_pkg::CMD_INV_VEC,   aft_pkg::Q_MIN, aft_pkg::Q_MAX, 32'h0);
        drain_results();
    endtask

    // Writes past the last register leave every coefficient alone
    task automatic test_unused_index();
        write_reg(REG_BEYOND_LO, {$urandom, $urandom}, 1'b0);
        write_reg(REG_BEYOND_HI, {$urandom, $urandom}, 1'b1);
        send_item(aft_pkg::CMD_POINT,     rand_coord(), rand_coord(), rand_coord());
        send_item(aft_pkg::CMD_VECTOR,    rand_coord(), rand_coord(), rand_coord());
        send_item(aft_pkg::CMD_INV_POINT, rand_coord(), rand_coord(), rand_coord());
        send_item(aft_pkg::CMD_INV_VEC,   rand_coord(), rand_coord(), rand_coord());
        drain_results();
    endtask

    task automatic test_random_phase(input coef_mix_t mix, input int count);
        program_matrix({rand_coef(mix), rand_coef(mix)}, {rand_coef(mix), rand_coef(mix)},
                       {rand_coef(mix), rand_coef(mix)}, {rand_coef(mix), rand_coef(mix)},
                       {rand_coef(mix), rand_coef(mix)}, {rand_coef(mix), rand_coef(mix)});
        gaps_on       = ($urandom_range(0, 3) != 0);
        sink_stall_en = ($urandom_range(0, 3) != 0);
        send_random(count);
        drain_results();
    endtask

    // Long output stall while input keeps coming, then a full pause
    task automatic test_input_backpressure();
        gaps_on       = 1'b0;
        sink_stall_en = 1'b0;
        hold_cycles   = LONG_HOLD;
        send_random(BURST_ITEMS);
        while (hold_cycles != 0) @(posedge aclk);
        drain_results();
    endtask

    task automatic test_reset_values_restored();
        program_matrix(aft_pkg::RST_ROW1_C12, aft_pkg::RST_ROW1_C3T, aft_pkg::RST_ROW2_C12,
                       aft_pkg::RST_ROW2_C3T, aft_pkg::RST_ROW3_C12, aft_pkg::RST_ROW3_C3T);
        gaps_on       = 1'b1;
        sink_stall_en = 1'b1;
        send_random(PHASE_ITEMS / 2);
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Result sink: random ready pattern, steady ready, or a counted hold-off
    // ------------------------------------------------------------------
    initial begin : result_sink
        logic [15:0] stall_pattern;
        int          slot;
        stall_pattern = 16'hFFFF;
        slot          = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else if (!sink_stall_en) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= stall_pattern[slot];
                slot = (slot + 1) % 16;
                if (slot == 0)
                    stall_pattern = $urandom_range(0, 1) ? (16'($urandom) | 16'($urandom))
                                                         : (16'($urandom) & 16'($urandom));
            end
        end
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : result_check
        xf_result_t want;
        int         k;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("result transaction with nothing outstanding",
                              m_tdata[31:0], 32'h0);
            end else begin
                want = pending_results.pop_front();
                for (k = 0; k < 3; k++)
                    if (m_tdata[32*k +: 32] !== want.r[k])
                        flag_mismatch(k == 0 ? "x_out" : (k == 1 ? "y_out" : "z_out"),
                                      m_tdata[32*k +: 32], want.r[k]);
                if (m_tuser !== want.ovf)
                    flag_mismatch("overflow", {31'b0, m_tuser}, {31'b0, want.ovf});
            end
        end
    end

    // Ends the run when no transaction moves for too long
    always @(posedge aclk) begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : test_sequence
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= aft_pkg::CMD_POINT;
        coef_regs[aft_pkg::REG_ROW1_C12] = aft_pkg::RST_ROW1_C12;
        coef_regs[aft_pkg::REG_ROW1_C3T] = aft_pkg::RST_ROW1_C3T;
        coef_regs[aft_pkg::REG_ROW2_C12] = aft_pkg::RST_ROW2_C12;
        coef_regs[aft_pkg::REG_ROW2_C3T] = aft_pkg::RST_ROW2_C3T;
        coef_regs[aft_pkg::REG_ROW3_C12] = aft_pkg::RST_ROW3_C12;
        coef_regs[aft_pkg::REG_ROW3_C3T] = aft_pkg::RST_ROW3_C3T;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_identity();
        test_saturation_corners();
        test_quarter_turn();
        test_unused_index();
        test_random_phase(COEF_FULL,    PHASE_ITEMS);
        test_random_phase(COEF_UNIT,    PHASE_ITEMS);
        test_random_phase(COEF_EXTREME, PHASE_ITEMS);
        test_random_phase(COEF_UNIT,    PHASE_ITEMS);
        test_random_phase(COEF_FULL,    PHASE_ITEMS);
        test_random_phase(COEF_UNIT,    PHASE_ITEMS);
        test_random_phase(COEF_EXTREME, PHASE_ITEMS);
        test_input_backpressure();
        test_reset_values_restored();

        drain_results();
        repeat (2 * PIPE_LATENCY) @(posedge aclk);
        if (pending_results.size() != 0)
            flag_mismatch("results never returned", pending_results.size(), 32'h0);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/aft_pkg.sv
rtl/core/aft_sub.sv
rtl/core/aft_mul.sv
rtl/core/aft_sum.sv
rtl/core/affine_point_transform.sv
dv/affine_point_transform_test.sv
